// ----- hw/rtl/mfr_pkg.sv -----
// Shared widths, constants and the sequencer microprogram of the multitap reverb.
package mfr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 24;
    localparam int OFF_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int SET_W      = OFF_W + GAIN_W;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_RING_DEPTH = 131072;
    localparam int DEF_TAP_COUNT  = 5;

    // 0.2 in Q0.16, and the wet gain applied to the stored sum.
    localparam int DRY_GAIN = 13107;
    localparam int WET_GAIN = 5;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] S_DRYMUL = 3'd1;
    localparam logic [STEP_W-1:0] S_DRYWR  = 3'd2;
    localparam logic [STEP_W-1:0] S_TAPRD  = 3'd3;
    localparam logic [STEP_W-1:0] S_DRAIN0 = 3'd4;
    localparam logic [STEP_W-1:0] S_DRAIN1 = 3'd5;
    localparam logic [STEP_W-1:0] S_WB     = 3'd6;
    localparam logic [STEP_W-1:0] S_OUT    = 3'd7;

    localparam int JMP_W = 2;
    localparam logic [JMP_W-1:0] J_SEQ     = 2'd0;
    localparam logic [JMP_W-1:0] J_ACCEPT  = 2'd1;
    localparam logic [JMP_W-1:0] J_TAPS    = 2'd2;
    localparam logic [JMP_W-1:0] J_OUTFREE = 2'd3;

    typedef struct packed {
        logic              dry_mul;
        logic              dry_wr;
        logic              rd_issue;
        logic              wb;
        logic              out_load;
        logic [JMP_W-1:0]  jmp;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Control store: one word per step. A step whose jump condition fails repeats.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        unique case (step)
            S_IDLE:   begin uc.jmp = J_ACCEPT;  uc.target = S_DRYMUL; end
            S_DRYMUL: begin uc.dry_mul = 1'b1; uc.jmp = J_SEQ; uc.target = S_DRYWR; end
            S_DRYWR:  begin uc.dry_wr = 1'b1; uc.jmp = J_SEQ; uc.target = S_TAPRD; end
            S_TAPRD:  begin uc.rd_issue = 1'b1; uc.jmp = J_TAPS; uc.target = S_DRAIN0; end
            S_DRAIN0: begin uc.jmp = J_SEQ;     uc.target = S_DRAIN1; end
            S_DRAIN1: begin uc.jmp = J_SEQ;     uc.target = S_WB; end
            S_WB:     begin uc.wb = 1'b1; uc.jmp = J_SEQ; uc.target = S_OUT; end
            S_OUT:    begin uc.out_load = 1'b1; uc.jmp = J_OUTFREE; uc.target = S_IDLE; end
        endcase
        return uc;
    endfunction

endpackage

// ----- hw/rtl/mfr_in_if.sv -----
// Input stream channel carrying one stereo dry frame per word.
interface mfr_in_if;
    import mfr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ----- hw/rtl/mfr_out_if.sv -----
// Output stream channel carrying one stereo mixed frame per word.
interface mfr_out_if;
    import mfr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- hw/rtl/multitap_feedback_reverb_core.sv -----
// Multitap feedback delay reverb: microcoded sequencer over one single-port delay ring.
// A frame is taken only in the idle step; it then runs dry multiply, dry write, the tap reads,
// a two-stage tap drain, write-back and an output load that waits for a free output, and only
// then is the next frame taken. The one ring port serves the dry write, one read per tap and
// the write-back. A tap register write holds off input while its offset is reduced.
// Reset clears control and tap registers; ring words not yet written since reset read as zero.
module multitap_feedback_reverb_core #(
    parameter int RING_DEPTH = mfr_pkg::DEF_RING_DEPTH,
    parameter int TAP_COUNT  = mfr_pkg::DEF_TAP_COUNT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    mfr_in_if.sink                                         dry_frame,
    mfr_out_if.source                                      mix_frame,
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [$clog2(TAP_COUNT > 1 ? TAP_COUNT : 2)+2:0] paddr,
    input  logic [mfr_pkg::CFG_DATA_W-1:0]                 pwdata,
    output logic [mfr_pkg::CFG_DATA_W-1:0]                 prdata,
    output logic                                           pready
);
    import mfr_pkg::*;

    localparam int PW     = $clog2(RING_DEPTH);
    localparam int TW     = $clog2(TAP_COUNT > 1 ? TAP_COUNT : 2);
    localparam int ADDR_W = TW + 3;
    localparam int ACC_W  = WORD_W + 2 + $clog2(TAP_COUNT + 1);
    localparam int PROD_W = GAIN_W + WORD_W;
    localparam int LR_W   = SAMPLE_W + 1;
    localparam int DRYP_W = 2 * LR_W;
    localparam int OUT_W  = WORD_W + 4;

    // Offset reduction modulo the ring depth by a reciprocal multiply and one correction.
    localparam int RECIP_SHIFT = OFF_W + PW;
    localparam int RECIP_W     = OFF_W + 1;
    localparam longint unsigned RECIP_L = (64'd1 << RECIP_SHIFT) / RING_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_L);
    localparam int RED_W = ((PW + 1) > OFF_W) ? (PW + 1) : OFF_W;

    localparam logic [PW:0]          DEPTH_C    = (PW + 1)'(RING_DEPTH);
    localparam logic [PW-1:0]        LAST_POS   = PW'(RING_DEPTH - 1);
    localparam logic [TW-1:0]        LAST_TAP   = TW'(TAP_COUNT - 1);
    localparam logic signed [LR_W-1:0] DRY_GAIN_S = LR_W'(DRY_GAIN);
    localparam logic signed [OUT_W-1:0] WET_GAIN_S = OUT_W'(WET_GAIN);
    localparam logic signed [ACC_W-1:0] WORD_MAX_A = ACC_W'((1 << (WORD_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] WORD_MIN_A = -ACC_W'(1 << (WORD_W - 1));
    localparam logic signed [OUT_W-1:0] SMP_MAX_O  = OUT_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0] SMP_MIN_O  = -OUT_W'(1 << (SAMPLE_W - 1));

    // ---------------- configuration registers ----------------
    logic [SET_W-1:0]         raw_set_reg [TAP_COUNT];
    logic signed [GAIN_W-1:0] gain_reg    [TAP_COUNT];
    logic [PW-1:0]            off_red_reg [TAP_COUNT];

    logic [TW-1:0]   cfg_idx;
    logic            cfg_hit;
    logic            cfg_wr;

    logic            red_v1_reg;
    logic [TW-1:0]   red_idx1_reg;
    logic [OFF_W-1:0] red_off1_reg;
    logic            red_v2_reg;
    logic [TW-1:0]   red_idx2_reg;
    logic [OFF_W-1:0] red_off2_reg;
    logic [OFF_W-1:0] red_q_reg;
    logic [OFF_W+RECIP_W-1:0] recip_prod;
    logic [OFF_W+PW:0] red_qd;
    logic [RED_W-1:0]  red_rem;
    logic [PW-1:0]     red_final;

    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_hit = int'(cfg_idx) < TAP_COUNT;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? CFG_DATA_W'(raw_set_reg[cfg_idx]) : '0;

    assign recip_prod = red_off1_reg * RECIP_C;
    assign red_qd     = red_q_reg * DEPTH_C;
    assign red_rem    = RED_W'(red_off2_reg) - RED_W'(red_qd);
    assign red_final  = (red_rem >= RED_W'(DEPTH_C)) ? PW'(red_rem - RED_W'(DEPTH_C))
                                                       : PW'(red_rem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                raw_set_reg[k] <= '0;
                gain_reg[k]    <= '0;
                off_red_reg[k] <= '0;
            end
            red_v1_reg <= 1'b0;
            red_v2_reg <= 1'b0;
        end
        else
        begin
            red_v1_reg <= cfg_wr && cfg_hit;
            red_v2_reg <= red_v1_reg;
            if (cfg_wr && cfg_hit)
            begin
                raw_set_reg[cfg_idx] <= pwdata[SET_W-1:0];
                gain_reg[cfg_idx]    <= pwdata[SET_W-1:OFF_W];
            end
            if (red_v2_reg)
            begin
                off_red_reg[red_idx2_reg] <= red_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        red_idx1_reg <= cfg_idx;
        red_off1_reg <= pwdata[OFF_W-1:0];
        red_idx2_reg <= red_idx1_reg;
        red_off2_reg <= red_off1_reg;
        red_q_reg    <= OFF_W'(recip_prod >> RECIP_SHIFT);
    end

    // ---------------- sequencer ----------------
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TW-1:0]     tap_reg, tap_next;
    ucode_t            uc;
    logic              in_acc;
    logic              tap_last;
    logic              out_free;
    logic              out_load;

    assign uc        = ucode_rom(step_reg);
    assign dry_frame.ready = (step_reg == S_IDLE) && !red_v1_reg && !red_v2_reg;
    assign in_acc    = dry_frame.valid && dry_frame.ready;
    assign tap_last  = tap_reg == LAST_TAP;
    assign out_free  = !mix_frame.valid || mix_frame.ready;
    assign out_load  = uc.out_load && out_free;

    always_comb
    begin
        step_next = step_reg;
        unique case (uc.jmp)
            J_SEQ:     step_next = uc.target;
            J_ACCEPT:  step_next = in_acc ? uc.target : step_reg;
            J_TAPS:    step_next = tap_last ? uc.target : step_reg;
            J_OUTFREE: step_next = out_free ? uc.target : step_reg;
        endcase
        tap_next = tap_reg;
        if (uc.dry_wr)
        begin
            tap_next = '0;
        end
        else if (uc.rd_issue && !tap_last)
        begin
            tap_next = tap_reg + 1'b1;
        end
    end

    // ---------------- datapath ----------------
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;
    logic signed [LR_W-1:0]     lr_sum;
    logic signed [DRYP_W-1:0]   dry_prod_reg;
    logic signed [DRYP_W-1:0]   dry_round;
    logic signed [WORD_W-1:0]   dry_word;

    logic [PW-1:0]   pos_reg, pos_next;
    logic            wrapped_reg;
    logic [PW:0]     idx_sum;
    logic [PW-1:0]   rd_idx;
    logic            rd_ok;

    logic            ram_we;
    logic [PW-1:0]   ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ring_mem [RING_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic                       rd_v_reg;
    logic                       rd_ok_reg;
    logic signed [GAIN_W-1:0]   rd_gain_reg;
    logic signed [GAIN_W-1:0]   mul_gain_reg;
    logic signed [WORD_W-1:0]   tap_word;
    logic                       mul_v_reg;
    logic signed [PROD_W-1:0]   tap_prod_reg;
    logic signed [PROD_W-1:0]   tap_round;

    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [WORD_W-1:0]   sat_word;
    logic signed [WORD_W-1:0]   sum_reg;
    logic signed [OUT_W-1:0]    wet, l_tot, r_tot;
    logic signed [SAMPLE_W-1:0] l_sat, r_sat;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_right_reg;

    assign lr_sum    = LR_W'(left_reg) + LR_W'(right_reg);
    assign dry_round = (dry_prod_reg + DRYP_W'(1 << 15)) >>> 16;
    // The dry word is 0.2 of the left plus right sum, at most 13107 in size, so it always fits a ring word.
    assign dry_word  = dry_round[WORD_W-1:0];

    assign idx_sum = {1'b0, pos_reg} + {1'b0, off_red_reg[tap_reg]};
    assign rd_idx  = (idx_sum >= DEPTH_C) ? PW'(idx_sum - DEPTH_C) : idx_sum[PW-1:0];
    // Positions are filled in order from zero, so anything past the write position has not been
    // written and reads as zero until the ring has wrapped once.
    assign rd_ok   = wrapped_reg || (rd_idx <= pos_reg);

    assign tap_word  = rd_ok_reg ? $signed(rdata_reg) : '0;
    assign tap_round = (tap_prod_reg + PROD_W'(1 << 13)) >>> 14;

    assign sat_word = (acc_reg > WORD_MAX_A) ? WORD_MAX_A[WORD_W-1:0] :
                      (acc_reg < WORD_MIN_A) ? WORD_MIN_A[WORD_W-1:0] : acc_reg[WORD_W-1:0];

    assign ram_we    = uc.dry_wr || uc.wb;
    assign ram_addr  = uc.rd_issue ? rd_idx : pos_reg;
    assign ram_wdata = uc.dry_wr ? dry_word : sat_word;

    assign wet   = OUT_W'(sum_reg) * WET_GAIN_S;
    assign l_tot = OUT_W'(left_reg) + wet;
    assign r_tot = OUT_W'(right_reg) + wet;
    assign l_sat = (l_tot > SMP_MAX_O) ? SMP_MAX_O[SAMPLE_W-1:0] :
                   (l_tot < SMP_MIN_O) ? SMP_MIN_O[SAMPLE_W-1:0] : l_tot[SAMPLE_W-1:0];
    assign r_sat = (r_tot > SMP_MAX_O) ? SMP_MAX_O[SAMPLE_W-1:0] :
                   (r_tot < SMP_MIN_O) ? SMP_MIN_O[SAMPLE_W-1:0] : r_tot[SAMPLE_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        if (uc.dry_wr)
        begin
            acc_next = ACC_W'(dry_word);
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg + tap_round[ACC_W-1:0];
        end
        pos_next = pos_reg;
        if (out_load)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ring_mem[ram_addr] <= ram_wdata;
        end
        if (uc.rd_issue)
        begin
            rdata_reg <= ring_mem[ram_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            tap_reg       <= '0;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            tap_reg   <= tap_next;
            pos_reg   <= pos_next;
            rd_v_reg  <= uc.rd_issue;
            mul_v_reg <= rd_v_reg;
            if (out_load && (pos_reg == LAST_POS))
            begin
                wrapped_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mix_frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            left_reg  <= dry_frame.left_in;
            right_reg <= dry_frame.right_in;
        end
        if (uc.dry_mul)
        begin
            dry_prod_reg <= lr_sum * DRY_GAIN_S;
        end
        if (uc.rd_issue)
        begin
            rd_ok_reg   <= rd_ok;
            rd_gain_reg <= gain_reg[tap_reg];
        end
        mul_gain_reg <= rd_gain_reg;
        tap_prod_reg <= rd_gain_reg * tap_word;
        acc_reg      <= acc_next;
        if (uc.wb)
        begin
            sum_reg <= sat_word;
        end
        if (out_load)
        begin
            out_left_reg  <= l_sat;
            out_right_reg <= r_sat;
        end
    end

    assign mix_frame.valid     = out_valid_reg;
    assign mix_frame.left_out  = out_left_reg;
    assign mix_frame.right_out = out_right_reg;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (step_reg == S_DRYMUL))
        else $error("accepted frame did not start the microprogram");

    a_port_shared: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && uc.rd_issue))
        else $error("ring port driven for read and write in one cycle");

    a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(pos_reg))
        else $error("write position moved without a result");

    a_tap_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_WB) |-> (!rd_v_reg && !mul_v_reg))
        else $error("tap pipeline still busy at write-back");

    a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
        red_v2_reg |-> ({1'b0, red_final} < DEPTH_C) &&
                       ({1'b0, red_rem} < (RED_W + 1)'(2 * RING_DEPTH)))
        else $error("reduced tap offset out of ring range");

    a_gain_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |=> (mul_gain_reg == $past(rd_gain_reg)))
        else $error("tap gain lost between read and multiply");

endmodule

// ----- test/tb_top.sv -----
// Testbench for the multitap feedback reverb core: stream and register stimulus, prediction, checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfr_pkg::*;

    localparam int RING_DEPTH = DEF_RING_DEPTH;
    localparam int TAP_COUNT  = DEF_TAP_COUNT;
    localparam int ADDR_W     = $clog2(TAP_COUNT > 1 ? TAP_COUNT : 2) + 3;

    localparam longint DRY_Q16  = 13107;
    localparam longint WET_MULT = 5;
    localparam longint WORD_MAX = 8388607;
    localparam longint WORD_MIN = -8388608;
    localparam longint PCM_MAX  = 32767;
    localparam longint PCM_MIN  = -32768;

    localparam int SETTLE_CYCLES = 2 * (TAP_COUNT + 7);
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;

    typedef enum int {
        TAP0_SETTING,
        TAP1_SETTING,
        TAP2_SETTING,
        TAP3_SETTING,
        TAP4_SETTING,
        TAP_REG_COUNT
    } tap_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    mfr_in_if  dry_bus();
    mfr_out_if mix_bus();

    multitap_feedback_reverb_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .dry_frame (dry_bus),
        .mix_frame (mix_bus),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Predictor state: the delay ring, the write position and the tap registers.
    bit signed [WORD_W-1:0] echo_ring [RING_DEPTH];
    logic [OFF_W-1:0]       write_pos = '0;
    logic [SET_W-1:0]       tap_reg [TAP_COUNT];

    stereo_t expected_mix[$];

    int  error_count     = 0;
    int  frames_sent     = 0;
    int  mixes_checked   = 0;
    int  settings_loaded = 0;
    int  quiet_cycles    = 0;
    bit  steady_flow     = 1'b0;
    bit  hold_request    = 1'b0;
    int  hold_span       = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic stereo_t reverb_mix(input stereo_t dry);
        longint                   acc;
        longint                   wet;
        int unsigned              idx;
        int                       k;
        logic [OFF_W-1:0]         offset;
        logic signed [GAIN_W-1:0] gain;
        stereo_t                  mixed;
        acc = round_shift((longint'(dry.left) + longint'(dry.right)) * DRY_Q16, 16);
        echo_ring[write_pos] = WORD_W'(saturate(acc, WORD_MIN, WORD_MAX));
        acc = echo_ring[write_pos];
        // All taps see the fresh dry word at the write position, not the later sum.
        for (k = 0; k < TAP_COUNT; k++) begin
            offset = tap_reg[k][OFF_W-1:0];
            gain = tap_reg[k][SET_W-1:OFF_W];
            idx = (int'(write_pos) + int'(offset)) % RING_DEPTH;
            acc += round_shift(longint'(gain) * longint'(echo_ring[idx]), 14);
        end
        echo_ring[write_pos] = WORD_W'(saturate(acc, WORD_MIN, WORD_MAX));
        wet = WET_MULT * longint'(echo_ring[write_pos]);
        mixed.left = SAMPLE_W'(saturate(longint'(dry.left) + wet, PCM_MIN, PCM_MAX));
        mixed.right = SAMPLE_W'(saturate(longint'(dry.right) + wet, PCM_MIN, PCM_MAX));
        write_pos = OFF_W'((int'(write_pos) + 1) % RING_DEPTH);
        return mixed;
    endfunction

    // Output side: random stalls, plus a long hold when a test asks for one.
    initial begin
        int held;
        mix_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                mix_bus.ready = 1'b0;
                for (held = 0; held < hold_span; held++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            mix_bus.ready = steady_flow || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk) begin
        stereo_t want;
        if (rst_n && mix_bus.valid === 1'b1 && mix_bus.ready === 1'b1) begin
            if (expected_mix.size() == 0) begin
                $display("%0t: unexpected mixed word left=%0d right=%0d", $time,
                         mix_bus.left_out, mix_bus.right_out);
                error_count++;
            end
            else begin
                want = expected_mix.pop_front();
                if (mix_bus.left_out !== want.left) begin
                    $display("%0t: left_out expected %0d got %0d", $time,
                             want.left, mix_bus.left_out);
                    error_count++;
                end
                if (mix_bus.right_out !== want.right) begin
                    $display("%0t: right_out expected %0d got %0d", $time,
                             want.right, mix_bus.right_out);
                    error_count++;
                end
                mixes_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if ((dry_bus.valid === 1'b1 && dry_bus.ready === 1'b1) ||
            (mix_bus.valid === 1'b1 && mix_bus.ready === 1'b1) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no word moved for %0d cycles, %0d mixed words still due", $time,
                 QUIET_LIMIT, expected_mix.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        int      gap;
        stereo_t frame;
        if (!steady_flow && $urandom_range(99) < 18) begin
            dry_bus.valid = 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        frame.left = l;
        frame.right = r;
        dry_bus.left_in = l;
        dry_bus.right_in = r;
        dry_bus.valid = 1'b1;
        @(posedge clk);
        while (dry_bus.ready !== 1'b1)
            @(posedge clk);
        expected_mix.push_back(reverb_mix(frame));
        frames_sent++;
        @(negedge clk);
    endtask

    task automatic write_tap_reg(input int index, input logic [CFG_DATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_W'(index * 8);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        // Writes past the last tap register are dropped by the block.
        if (index < TAP_COUNT)
            tap_reg[index] = value[SET_W-1:0];
        settings_loaded++;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic settle_idle();
        dry_bus.valid = 1'b0;
        while (expected_mix.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_tap_setting();
        logic [OFF_W-1:0]  offset;
        logic [GAIN_W-1:0] gain;
        int unsigned       pick;
        pick = $urandom_range(99);
        // Offsets just short of the ring length read recent words and give real echoes.
        if (pick < 45)
            offset = OFF_W'(RING_DEPTH - int'($urandom_range(1, 300)));
        else if (pick < 60)
            offset = '0;
        else if (pick < 70)
            offset = '1;
        else if (pick < 80)
            offset = OFF_W'($urandom_range(1, 64));
        else
            offset = OFF_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
            gain = GAIN_W'($urandom);
        else if (pick < 45)
            gain = 16'h7FFF;
        else if (pick < 50)
            gain = 16'h8000;
        else
            gain = GAIN_W'(int'($urandom_range(0, 12000)) - 6000);
        return {(CFG_DATA_W - SET_W)'($urandom), gain, offset};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return SAMPLE_W'($urandom);
        else if (pick < 88)
            return SAMPLE_W'(int'($urandom_range(0, 6000)) - 3000);
        else if (pick < 94)
            return 16'sh7FFF;
        else
            return 16'sh8000;
    endfunction

    // Taps at reset have zero gain, so only the dry word path, its rounding and the output saturation show.
    task automatic test_reset_taps();
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(-16'sd1, -16'sd1);
        send_frame(16'sd5, 16'sd0);
        send_frame(-16'sd5, 16'sd0);
        send_frame(16'sd1000, -16'sd1000);
        send_frame(-16'sd2, -16'sd3);
        settle_idle();
    endtask

    task automatic test_extreme_taps();
        int k;
        // A tap at offset zero reads the fresh dry word; all-ones offsets wrap to the previous frame's word.
        write_tap_reg(TAP0_SETTING, {31'd0, 16'h7FFF, 17'd0});
        write_tap_reg(TAP1_SETTING, {31'd0, 16'h8000, 17'h1FFFF});
        write_tap_reg(TAP2_SETTING, {CFG_DATA_W{1'b1}});
        write_tap_reg(TAP3_SETTING, {31'd0, 16'h4000, 17'd2});
        write_tap_reg(TAP4_SETTING, {31'd0, 16'h7FFF, OFF_W'(RING_DEPTH - 2)});
        for (k = TAP_REG_COUNT; k < (1 << ADDR_W) / 8; k++)
            write_tap_reg(k, {CFG_DATA_W{1'b1}});
        for (k = 0; k < 4; k++)
            send_frame(16'sh7FFF, 16'sh7FFF);
        for (k = 0; k < 4; k++)
            send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sd0, 16'sd0);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sd12, -16'sd7);
        settle_idle();
    endtask

    task automatic test_random_echoes();
        int setting;
        int k;
        int n;
        for (setting = 0; setting < 6; setting++) begin
            for (k = 0; k < TAP_COUNT; k++)
                write_tap_reg(k, random_tap_setting());
            for (n = 0; n < 125; n++)
                send_frame(random_sample(), random_sample());
            settle_idle();
        end
    endtask

    task automatic test_steady_stream();
        int k;
        int n;
        for (k = 0; k < TAP_COUNT; k++)
            write_tap_reg(k, random_tap_setting());
        steady_flow = 1'b1;
        for (n = 0; n < 100; n++)
            send_frame(random_sample(), random_sample());
        settle_idle();
        steady_flow = 1'b0;
    endtask

    // The output side holds off while words keep coming, so the core must stall its input.
    task automatic test_output_hold();
        int n;
        hold_span = HOLD_CYCLES;
        hold_request = 1'b1;
        for (n = 0; n < 60; n++)
            send_frame(random_sample(), random_sample());
        settle_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        dry_bus.valid = 1'b0;
        dry_bus.left_in = '0;
        dry_bus.right_in = '0;
        for (int k = 0; k < TAP_COUNT; k++)
            tap_reg[k] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_taps();
        test_extreme_taps();
        test_random_echoes();
        test_steady_stream();
        test_output_hold();
        settle_idle();
        $display("Run covered %0d dry words and %0d checked mixed words over %0d register writes,",
                 frames_sent, mixes_checked, settings_loaded);
        $display("with zero, extreme and random echo taps, a gap-free stretch and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
